// ===== src/sga_pkg.sv =====
// ----------------------------------------------------------------------------
// sga_pkg
// Shared types, constants and command structures of the softened gravity
// accumulator.
// ----------------------------------------------------------------------------
package sga_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned DIFF_W  = 33;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned HALF_W  = 16;   // operand slice of the split products
    localparam int unsigned S_W     = 50;   // sum of squares plus softening
    localparam int unsigned T_W     = 32;   // integer square root of s * 2^14
    localparam int unsigned DEN_W   = 82;
    localparam int unsigned NUM_W   = 88;
    localparam int unsigned QUO_W   = 49;   // quotients clamp at 2^48
    localparam int unsigned AXES    = 3;
    localparam int unsigned SQ_STEPS  = 32;
    localparam int unsigned DIV_STEPS = 88;
    localparam int unsigned CNT_W   = 7;

    localparam int unsigned IDX_SOFT  = 0;
    localparam int unsigned IDX_GRAV  = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQRT,
        ST_DEN,
        ST_DIV,
        ST_ACC,
        ST_EMIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;      // capture the input item and form differences
        logic       prep;      // add the squared difference of the current axis
        logic       sqrt_step; // one square root iteration
        logic       den;       // one half of s * t
        logic       div_start; // set up the division for the current axis
        logic       div_step;  // one restoring division step
        logic       acc;       // add the contribution of the current axis
        logic       emit;      // one half of the scaling of the current axis
        logic       phase;     // low or high half of a split product
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic is_last;
    } t_status;

endpackage

// ===== src/sga_ctrl.sv =====
// ----------------------------------------------------------------------------
// sga_ctrl
// Sequencer: steps the datapath through prepare, square root, denominator,
// division per axis, accumulation and final scaling.
// ----------------------------------------------------------------------------
module sga_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_out_taken,
    input  sga_pkg::t_status i_status,
    output sga_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_out_valid
);
    import sga_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_PREP;
                    n_cnt   = '0;
                    n_axis  = '0;
                end
            end
            ST_PREP: begin
                if (r_axis == 2'(AXES - 1)) begin
                    n_axis  = '0;
                    n_cnt   = '0;
                    n_state = ST_SQRT;
                end else begin
                    n_axis = r_axis + 1'b1;
                end
            end
            ST_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DEN;
                end
            end
            ST_DEN: begin
                if (r_cnt == '0) begin
                    n_cnt = CNT_W'(1);
                end else begin
                    n_axis = '0;
                    n_cnt  = '0;
                    if (i_status.den_zero) begin
                        n_state = i_status.is_last ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS)) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_cnt = '0;
                if (r_axis == 2'(AXES - 1)) begin
                    n_axis  = '0;
                    n_state = i_status.is_last ? ST_EMIT : ST_IDLE;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_EMIT: begin
                if (r_cnt == '0) begin
                    n_cnt = CNT_W'(1);
                end else begin
                    n_cnt = '0;
                    if (r_axis == 2'(AXES - 1)) begin
                        n_axis  = '0;
                        n_state = ST_OUT;
                    end else begin
                        n_axis = r_axis + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (i_out_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.axis      = r_axis;
        o_cmd.phase     = r_cnt[0];
        o_cmd.load      = (r_state == ST_IDLE) && i_start;
        o_cmd.prep      = (r_state == ST_PREP);
        o_cmd.sqrt_step = (r_state == ST_SQRT);
        o_cmd.den       = (r_state == ST_DEN);
        o_cmd.div_start = (r_state == ST_DIV) && (r_cnt == '0);
        o_cmd.div_step  = (r_state == ST_DIV) && (r_cnt != '0);
        o_cmd.acc       = (r_state == ST_ACC);
        o_cmd.emit      = (r_state == ST_EMIT);
        o_busy          = (r_state != ST_IDLE);
        o_out_valid     = (r_state == ST_OUT);
    end

endmodule

// ===== src/sga_datapath.sv =====
// ----------------------------------------------------------------------------
// sga_datapath
// Differences, softened distance, iterative square root, restoring divider,
// saturating accumulators and final scaling.
// ----------------------------------------------------------------------------
module sga_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sga_pkg::t_cmd              i_cmd,
    input  logic                       i_first,
    input  logic                       i_last,
    input  logic [sga_pkg::POS_W-1:0]  i_target_x,
    input  logic [sga_pkg::POS_W-1:0]  i_target_y,
    input  logic [sga_pkg::POS_W-1:0]  i_target_z,
    input  logic [sga_pkg::POS_W-1:0]  i_other_x,
    input  logic [sga_pkg::POS_W-1:0]  i_other_y,
    input  logic [sga_pkg::POS_W-1:0]  i_other_z,
    input  logic [sga_pkg::POS_W-1:0]  i_other_mass,
    input  logic [sga_pkg::CFG_W-1:0]  i_soft_squared,
    input  logic [sga_pkg::CFG_W-1:0]  i_grav_const,
    output sga_pkg::t_status           o_status,
    output logic [sga_pkg::SUM_W-1:0]  o_accel_x,
    output logic [sga_pkg::SUM_W-1:0]  o_accel_y,
    output logic [sga_pkg::SUM_W-1:0]  o_accel_z,
    output logic                       o_overflow
);
    import sga_pkg::*;

    localparam logic signed [SUM_W:0] MAX_S = {2'b00, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W:0] MIN_S = {2'b11, {(SUM_W-1){1'b0}}};

    logic [DIFF_W-2:0]  r_mag [AXES];   // magnitudes of the differences
    logic [AXES-1:0]    r_neg;
    logic [POS_W-1:0]   r_mass;
    logic               r_last;
    logic [S_W-1:0]     r_s;
    logic [T_W-1:0]     r_rem_sq;       // square root radicand remainder
    logic [T_W-1:0]     r_root;
    logic [4:0]         r_sq_idx;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W:0]     r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic               r_quo_big;
    logic signed [SUM_W-1:0] r_sum [AXES];
    logic               r_sat;
    logic signed [SUM_W-1:0] r_out [AXES];
    logic               r_out_sat;
    logic [SUM_W+HALF_W-1:0] r_eprod;

    logic [2*DIFF_W-3:0] w_sq;
    logic [S_W-1:0]      w_s;
    logic signed [DIFF_W-1:0] w_d [AXES];

    assign w_d[0] = $signed({i_other_x[POS_W-1], i_other_x})
                  - $signed({i_target_x[POS_W-1], i_target_x});
    assign w_d[1] = $signed({i_other_y[POS_W-1], i_other_y})
                  - $signed({i_target_y[POS_W-1], i_target_y});
    assign w_d[2] = $signed({i_other_z[POS_W-1], i_other_z})
                  - $signed({i_target_z[POS_W-1], i_target_z});

    // One squared difference per cycle; the first axis starts from softening.
    assign w_sq = r_mag[i_cmd.axis] * r_mag[i_cmd.axis];
    assign w_s  = ((i_cmd.axis == 2'd0) ? S_W'(i_soft_squared) : r_s)
                + S_W'(w_sq >> 16);

    // Square root: two radicand bits per step, one root bit out.
    logic [2*T_W-1:0] w_rad;
    logic [T_W+1:0]   w_trial;
    logic [T_W+1:0]   w_part;
    assign w_rad   = {r_s, 14'b0};
    assign w_part  = {r_rem_sq, w_rad[2*r_sq_idx+1 -: 2]};
    assign w_trial = {r_root, 2'b01};

    // Denominator s * t, formed from the two halves of the root.
    logic [HALF_W-1:0]   w_root_half;
    logic [S_W+HALF_W-1:0] w_den_part;
    assign w_root_half = i_cmd.phase ? r_root[T_W-1:HALF_W] : r_root[HALF_W-1:0];
    assign w_den_part  = r_s * w_root_half;

    // Numerator mass * |d| of the current axis.
    logic [2*POS_W-1:0] w_mp;
    assign w_mp = r_mass * r_mag[i_cmd.axis];

    // Restoring division step.
    logic [DEN_W:0] w_shift;
    assign w_shift = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};

    // Contribution and saturating sum of the current axis.
    logic signed [SUM_W+1:0] w_c;
    logic signed [SUM_W+1:0] w_add;
    logic                    w_c_sat;
    always_comb begin
        logic [QUO_W-1:0] q;
        q = r_quo_big ? QUO_W'(1) << SUM_W : r_quo;
        w_c = r_neg[i_cmd.axis] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        w_c_sat = 1'b0;
        if (w_c > MAX_S) begin
            w_c = MAX_S; w_c_sat = 1'b1;
        end else if (w_c < MIN_S) begin
            w_c = MIN_S; w_c_sat = 1'b1;
        end
        w_add = w_c + (SUM_W+2)'(r_sum[i_cmd.axis]);
    end

    // Final scaling of the current axis, the constant taken in two halves.
    logic [SUM_W-1:0]         w_abs;
    logic [HALF_W-1:0]        w_g_half;
    logic [SUM_W+HALF_W-1:0]  w_eprod;
    logic [SUM_W+CFG_W-1:0]   w_prod;
    logic [SUM_W+CFG_W-17:0]  w_q;
    logic [SUM_W-1:0]         w_v;
    logic                     w_v_sat;
    always_comb begin
        w_abs    = r_sum[i_cmd.axis][SUM_W-1] ? SUM_W'(-r_sum[i_cmd.axis])
                                              : r_sum[i_cmd.axis];
        w_g_half = i_cmd.phase ? i_grav_const[CFG_W-1:HALF_W]
                               : i_grav_const[HALF_W-1:0];
        w_eprod  = w_abs * w_g_half;
        w_prod   = {{HALF_W{1'b0}}, r_eprod} + {w_eprod, {HALF_W{1'b0}}};
        w_q      = w_prod[SUM_W+CFG_W-1:16];
        w_v_sat  = 1'b0;
        if (!r_sum[i_cmd.axis][SUM_W-1]) begin
            // Positive values clip above 2^47 - 1.
            if (|w_q[SUM_W+CFG_W-17:SUM_W-1]) begin
                w_v = MAX_S[SUM_W-1:0]; w_v_sat = 1'b1;
            end else begin
                w_v = w_q[SUM_W-1:0];
            end
        end else begin
            // Negative values clip below -2^47.
            if ((|w_q[SUM_W+CFG_W-17:SUM_W])
                    || (w_q[SUM_W-1] && (|w_q[SUM_W-2:0]))) begin
                w_v = MIN_S[SUM_W-1:0]; w_v_sat = 1'b1;
            end else begin
                w_v = -w_q[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) r_sum[k] <= '0;
            r_sat <= 1'b0;
        end else begin
            if (i_cmd.load && i_first) begin
                for (int k = 0; k < AXES; k++) r_sum[k] <= '0;
                r_sat <= 1'b0;
            end
            if (i_cmd.acc) begin
                if (w_add > MAX_S) begin
                    r_sum[i_cmd.axis] <= MAX_S[SUM_W-1:0]; r_sat <= 1'b1;
                end else if (w_add < MIN_S) begin
                    r_sum[i_cmd.axis] <= MIN_S[SUM_W-1:0]; r_sat <= 1'b1;
                end else begin
                    r_sum[i_cmd.axis] <= w_add[SUM_W-1:0];
                    if (w_c_sat) r_sat <= 1'b1;
                end
            end
            if (i_cmd.emit && i_cmd.phase && w_v_sat) r_sat <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < AXES; k++) begin
                r_neg[k] <= w_d[k][DIFF_W-1];
                r_mag[k] <= w_d[k][DIFF_W-1] ? (DIFF_W-1)'(-w_d[k])
                                             : w_d[k][DIFF_W-2:0];
            end
            r_mass <= i_other_mass;
            r_last <= i_last;
        end
        if (i_cmd.prep) begin
            r_s      <= w_s;
            r_rem_sq <= '0;
            r_root   <= '0;
            r_sq_idx <= 5'(T_W - 1);
        end
        if (i_cmd.sqrt_step) begin
            r_sq_idx <= r_sq_idx - 1'b1;
            if (w_part >= w_trial) begin
                r_rem_sq <= T_W'(w_part - w_trial);
                r_root   <= {r_root[T_W-2:0], 1'b1};
            end else begin
                r_rem_sq <= T_W'(w_part);
                r_root   <= {r_root[T_W-2:0], 1'b0};
            end
        end
        if (i_cmd.den) begin
            if (i_cmd.phase) begin
                r_den <= r_den + {w_den_part, {HALF_W{1'b0}}};
            end else begin
                r_den <= {{HALF_W{1'b0}}, w_den_part};
            end
        end
        if (i_cmd.div_start) begin
            r_num     <= {1'b0, w_mp, 23'b0};
            r_rem     <= '0;
            r_quo     <= '0;
            r_quo_big <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            if (r_quo[QUO_W-1]) r_quo_big <= 1'b1;
            if (w_shift >= {1'b0, r_den}) begin
                r_rem <= w_shift - {1'b0, r_den};
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.acc && r_quo > ((QUO_W)'(1) << SUM_W)) begin
            r_quo_big <= 1'b1;
        end
        if (i_cmd.emit) begin
            if (!i_cmd.phase) begin
                r_eprod <= w_eprod;
            end else begin
                r_out[i_cmd.axis] <= w_v;
                if (i_cmd.axis == 2'(AXES - 1)) r_out_sat <= r_sat | w_v_sat;
            end
        end
    end

    // The root is at least 128 whenever s is nonzero, so s alone decides.
    assign o_status.den_zero = (r_s == '0);
    assign o_status.is_last  = r_last;
    assign o_accel_x  = r_out[0];
    assign o_accel_y  = r_out[1];
    assign o_accel_z  = r_out[2];
    assign o_overflow = r_out_sat;

endmodule

// ===== src/softened_gravity_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// softened_gravity_accumulator_core
// Plummer-softened pairwise gravity accumulator with saturating Q24.24 sums.
// ----------------------------------------------------------------------------
// Each input transaction adds one body's pull on a target particle to three
// acceleration sums; tuser bit 0 (first) clears them beforehand and tlast
// emits the sums scaled by the gravity constant. The input stays closed
// while an item is processed: the softened distance is formed axis by axis,
// a 32-step square root and a denominator product in two halves follow, and
// a bit-serial 88-step restoring divider then runs with one accumulate step
// on each axis; divider and accumulation are skipped when the softened
// distance is zero. A last item adds the scaling, in two halves per axis,
// and then holds the result until it is taken, keeping the input closed
// until its transaction completes. Write configuration while idle.
module softened_gravity_accumulator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // target_x, target_y, target_z, other_x, other_y, other_z, other_mass
    input  logic [223:0]  s_axis_tdata,
    input  logic          s_axis_tlast,
    // first
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // accel_x, accel_y, accel_z
    output logic [143:0]  m_axis_tdata,
    // overflow
    output logic          m_axis_tuser,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [sga_pkg::CFG_W-1:0] i_cfg_data
);
    import sga_pkg::*;

    logic [CFG_W-1:0] r_soft_squared;
    logic [CFG_W-1:0] r_grav_const;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;

    // The configuration registers are plain write-only flops.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft_squared <= CFG_W'(65536);
            r_grav_const   <= CFG_W'(65536);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == 1'(IDX_SOFT)) r_soft_squared <= i_cfg_data;
            if (i_cfg_idx == 1'(IDX_GRAV)) r_grav_const   <= i_cfg_data;
        end
    end

    assign s_axis_tready = !w_busy;

    sga_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid && s_axis_tready),
        .i_out_taken (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_busy      (w_busy),
        .o_out_valid (m_axis_tvalid)
    );

    sga_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_first        (s_axis_tuser),
        .i_last         (s_axis_tlast),
        .i_target_x     (s_axis_tdata[31:0]),
        .i_target_y     (s_axis_tdata[63:32]),
        .i_target_z     (s_axis_tdata[95:64]),
        .i_other_x      (s_axis_tdata[127:96]),
        .i_other_y      (s_axis_tdata[159:128]),
        .i_other_z      (s_axis_tdata[191:160]),
        .i_other_mass   (s_axis_tdata[223:192]),
        .i_soft_squared (r_soft_squared),
        .i_grav_const   (r_grav_const),
        .o_status       (w_status),
        .o_accel_x      (m_axis_tdata[47:0]),
        .o_accel_y      (m_axis_tdata[95:48]),
        .o_accel_z      (m_axis_tdata[143:96]),
        .o_overflow     (m_axis_tuser)
    );

endmodule

// ===== src/sga_checker.sv =====
// ----------------------------------------------------------------------------
// sga_checker
// Port-level checks of the accumulator handshakes.
// ----------------------------------------------------------------------------
module sga_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [143:0] m_axis_tdata
);
    // A pending result keeps the input side closed.
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open while result waits");

    // An accepted item closes the input on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still open after accept");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");
endmodule

bind softened_gravity_accumulator_core sga_checker u_sga_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
